/* rtl/ssre_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssre_pkg: shared types and constants of the stencil row engine
// Field widths, opcodes, register indexes and the front-to-back word layout.
// ----------------------------------------------------------------------------
package ssre_pkg;

	localparam int HALO_DEPTH_DEF  = 8192;
	localparam int MAX_STRIPES_DEF = 32;
	localparam int QUEUE_DEPTH     = 4;
	localparam int DIV_W           = 50;
	localparam int DIVISOR_W       = 16;
	localparam int HALO_IDX_W      = 13;
	localparam int CFG_DATA_W      = 16;
	localparam int CFG_IDX_W       = 3;

	typedef enum logic [1:0] {
		MODE_LOAD_X   = 2'd0,
		MODE_LOAD_OFF = 2'd1,
		MODE_MAC      = 2'd2,
		MODE_NONE     = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_LOCAL_X  = 3'd0,
		REG_LOCAL_Y  = 3'd1,
		REG_GLOBAL_X = 3'd2,
		REG_GLOBAL_Y = 3'd3,
		REG_GLOBAL_Z = 3'd4,
		REG_ORIGIN_X = 3'd5,
		REG_ORIGIN_Y = 3'd6,
		REG_ORIGIN_Z = 3'd7
	} reg_idx_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_MAC  = 1'b1
	} op_kind_t;

	typedef struct packed {
		logic [4:0]  local_x_size;
		logic [4:0]  local_y_size;
		logic [15:0] global_x_size;
		logic [15:0] global_y_size;
		logic [15:0] global_z_size;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [15:0] origin_z;
	} cfg_t;

	typedef struct packed {
		op_kind_t                kind;
		logic                    hit;
		logic                    last;
		logic [HALO_IDX_W-1:0]   halo_index;
		logic [63:0]             value;
	} op_ctrl_t;

endpackage
`default_nettype wire

/* rtl/ssre_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssre_if: input and result channels of the stencil row engine
// Valid/ready channels, one word moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface ssre_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [12:0] slot;
	logic [11:0] row;
	logic [63:0] value;
	logic        row_end;

	modport source(output valid, output mode, output slot, output row, output value,
		output row_end, input ready);
	modport sink(input valid, input mode, input slot, input row, input value,
		input row_end, output ready);
endinterface

interface ssre_result_if;
	logic        valid;
	logic        ready;
	logic [12:0] halo_index;
	logic [63:0] row_sum;

	modport source(output valid, output halo_index, output row_sum, input ready);
	modport sink(input valid, input halo_index, input row_sum, output ready);
endinterface
`default_nettype wire

/* rtl/ssre_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssre_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulses for one cycle.
// ----------------------------------------------------------------------------
module ssre_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ssre_pkg::DIV_W-1:0]     dividend,
	input  logic [ssre_pkg::DIVISOR_W-1:0] divisor,
	output logic                           done,
	output logic [ssre_pkg::DIV_W-1:0]     quotient,
	output logic [ssre_pkg::DIVISOR_W-1:0] remainder
);
	import ssre_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [DIVISOR_W:0]   rem_sh;
	logic [DIVISOR_W:0]   rem_sub;
	logic                 take;

	always_comb begin
		rem_sh  = {rem_q, quo_q[DIV_W-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		take    = rem_sh >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], take};
			rem_q <= take ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

/* rtl/ssre_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssre_front: item intake and index arithmetic
// Loads the stripe table, maps rows and neighbors to halo addresses.
// ----------------------------------------------------------------------------
module ssre_front #(
	parameter int HALO_DEPTH  = ssre_pkg::HALO_DEPTH_DEF,
	parameter int MAX_STRIPES = ssre_pkg::MAX_STRIPES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ssre_pkg::cfg_t                    cfg,
	ssre_item_if.sink                         item,
	output logic                              push_valid,
	input  logic                              push_ready,
	output ssre_pkg::op_ctrl_t                push_ctrl,
	output logic [$clog2(HALO_DEPTH)-1:0]     push_addr
);
	import ssre_pkg::*;

	localparam int AW = $clog2(HALO_DEPTH);
	localparam int SW = (MAX_STRIPES > 1) ? $clog2(MAX_STRIPES) : 1;

	typedef enum logic [4:0] {
		F_IDLE, F_SDIV, F_RDIV1, F_RDIV2, F_M1, F_M2, F_M3, F_M4, F_GI, F_GJ,
		F_RANGE, F_HDIV1, F_HDIV2, F_HA, F_HB, F_HC, F_PUSH
	} fstate_t;

	fstate_t state_q;

	logic accept;
	logic div_start;
	logic [DIV_W-1:0]     div_dividend;
	logic [DIVISOR_W-1:0] div_divisor;
	logic                 div_done;
	logic [DIV_W-1:0]     div_quot;
	logic [DIVISOR_W-1:0] div_rem;

	logic [4:0]  nx_e, ny_e;
	logic [15:0] gnx_e, gny_e, gnz_e;

	logic [1:0]  mode_q;
	logic [12:0] slot_q;
	logic [11:0] row_q;
	logic [63:0] value_q;
	logic        row_end_q;

	logic [63:0] off_mem [MAX_STRIPES];
	logic [63:0] off_rd_q;
	logic [SW-1:0] stripe_idx;

	logic [4:0]  lx_q, ly_q;
	logic [11:0] lz_q;
	logic [31:0] gxy_q;
	logic [32:0] t1_q;
	logic [48:0] t2_q;
	logic [47:0] tot_q;
	logic [49:0] gi_q;
	logic [65:0] gj_q;
	logic        hit;
	logic        hit_q;
	logic        sel_gj_q;

	logic [15:0] hx_q, hy_q;
	logic [AW-1:0] hz_q;
	logic [AW-1:0] ty_q, tz_q, nn_q;
	logic [AW-1:0] hy_t, hz_t, hx_t, nx2, halo_sum;
	logic [11:0]   nn_full;
	logic [AW-1:0] addr_q;
	logic [HALO_IDX_W-1:0] ohalo_q;

	// a size register of zero acts as one
	always_comb begin
		nx_e  = (cfg.local_x_size  == '0) ? 5'd1  : cfg.local_x_size;
		ny_e  = (cfg.local_y_size  == '0) ? 5'd1  : cfg.local_y_size;
		gnx_e = (cfg.global_x_size == '0) ? 16'd1 : cfg.global_x_size;
		gny_e = (cfg.global_y_size == '0) ? 16'd1 : cfg.global_y_size;
		gnz_e = (cfg.global_z_size == '0) ? 16'd1 : cfg.global_z_size;
	end

	assign item.ready = (state_q == F_IDLE);
	assign accept     = item.valid && (state_q == F_IDLE);
	// stripe count is a power of two, the low slot bits pick the stripe
	assign stripe_idx = (MAX_STRIPES > 1) ? slot_q[SW-1:0] : '0;

	always_comb begin
		hit      = !gj_q[65] && (gj_q[64:0] < 65'(tot_q));
		nx2      = AW'(nx_e) + AW'(2);
		nn_full  = (12'(nx_e) + 12'd2) * (12'(ny_e) + 12'd2);
		hy_t     = AW'(hy_q) - AW'(cfg.origin_y) + AW'(1);
		hz_t     = hz_q - AW'(cfg.origin_z) + AW'(1);
		hx_t     = AW'(hx_q) - AW'(cfg.origin_x) + AW'(1);
		halo_sum = hx_t + ty_q + tz_q;
	end

	// divider requests
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			F_SDIV: begin
				if (mode_q == MODE_MAC) begin
					div_start    = 1'b1;
					div_dividend = DIV_W'(row_q);
					div_divisor  = DIVISOR_W'(nx_e);
				end
			end
			F_RDIV1: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = div_quot;
					div_divisor  = DIVISOR_W'(ny_e);
				end
			end
			F_RANGE: begin
				if (hit) begin
					div_start    = 1'b1;
					div_dividend = gj_q[DIV_W-1:0];
					div_divisor  = gnx_e;
				end else if (row_end_q) begin
					div_start    = 1'b1;
					div_dividend = gi_q;
					div_divisor  = gnx_e;
				end
			end
			F_HDIV1: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = div_quot;
					div_divisor  = gny_e;
				end
			end
			F_HC: begin
				if (sel_gj_q && row_end_q) begin
					div_start    = 1'b1;
					div_dividend = gi_q;
					div_divisor  = gnx_e;
				end
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	ssre_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						case (item.mode)
							MODE_LOAD_X:   state_q <= F_PUSH;
							MODE_LOAD_OFF: state_q <= F_SDIV;
							MODE_MAC:      state_q <= F_SDIV;
							default:       state_q <= F_IDLE;
						endcase
					end
				end
				F_SDIV: begin
					state_q <= (mode_q == MODE_MAC) ? F_RDIV1 : F_IDLE;
				end
				F_RDIV1: if (div_done) state_q <= F_RDIV2;
				F_RDIV2: if (div_done) state_q <= F_M1;
				F_M1:    state_q <= F_M2;
				F_M2:    state_q <= F_M3;
				F_M3:    state_q <= F_M4;
				F_M4:    state_q <= F_GI;
				F_GI:    state_q <= F_GJ;
				F_GJ:    state_q <= F_RANGE;
				F_RANGE: begin
					if (hit || row_end_q) begin
						state_q <= F_HDIV1;
					end else begin
						state_q <= F_IDLE;
					end
				end
				F_HDIV1: if (div_done) state_q <= F_HDIV2;
				F_HDIV2: if (div_done) state_q <= F_HA;
				F_HA:    state_q <= F_HB;
				F_HB:    state_q <= F_HC;
				F_HC: begin
					state_q <= (sel_gj_q && row_end_q) ? F_HDIV1 : F_PUSH;
				end
				F_PUSH:  if (push_ready) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// stripe offset table, one port
	always_ff @(posedge clk) begin
		if (state_q == F_SDIV) begin
			if (mode_q == MODE_LOAD_OFF) begin
				off_mem[stripe_idx] <= value_q;
			end
			off_rd_q <= off_mem[stripe_idx];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					mode_q    <= item.mode;
					slot_q    <= item.slot;
					row_q     <= item.row;
					value_q   <= item.value;
					row_end_q <= item.row_end;
				end
			end
			F_RDIV1: if (div_done) lx_q <= div_rem[4:0];
			F_RDIV2: begin
				if (div_done) begin
					ly_q <= div_rem[4:0];
					lz_q <= div_quot[11:0];
				end
			end
			F_M1: gxy_q <= 32'(gnx_e) * 32'(gny_e);
			F_M2: t1_q  <= (33'(cfg.origin_y) + 33'(ly_q)) * 33'(gnx_e);
			F_M3: t2_q  <= (49'(cfg.origin_z) + 49'(lz_q)) * 49'(gxy_q);
			F_M4: tot_q <= 48'(gxy_q) * 48'(gnz_e);
			F_GI: gi_q  <= 50'(cfg.origin_x) + 50'(lx_q) + 50'(t1_q) + 50'(t2_q);
			F_GJ: gj_q  <= {16'd0, gi_q} + {{2{off_rd_q[63]}}, off_rd_q};
			F_RANGE: begin
				hit_q    <= hit;
				sel_gj_q <= hit;
			end
			F_HDIV1: if (div_done) hx_q <= div_rem;
			F_HDIV2: begin
				if (div_done) begin
					hy_q <= div_rem;
					hz_q <= AW'(div_quot);
				end
			end
			F_HA: begin
				ty_q <= hy_t * nx2;
				nn_q <= AW'(nn_full);
			end
			F_HB: tz_q <= hz_t * nn_q;
			F_HC: begin
				if (sel_gj_q) begin
					addr_q <= halo_sum;
				end else begin
					ohalo_q <= HALO_IDX_W'(halo_sum);
				end
				sel_gj_q <= 1'b0;
			end
			default: begin
				hit_q <= hit_q;
			end
		endcase
	end

	assign push_valid = (state_q == F_PUSH);

	always_comb begin
		push_ctrl.kind       = (mode_q == MODE_LOAD_X) ? OP_LOAD : OP_MAC;
		push_ctrl.hit        = hit_q;
		push_ctrl.last       = row_end_q;
		push_ctrl.halo_index = ohalo_q;
		push_ctrl.value      = value_q;
		push_addr            = (mode_q == MODE_LOAD_X) ? AW'(slot_q) : addr_q;
	end

endmodule
`default_nettype wire

/* rtl/ssre_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssre_queue: small word queue between front and back
// Register based fifo with an occupancy count.
// ----------------------------------------------------------------------------
module ssre_queue #(
	parameter int W     = 8,
	parameter int DEPTH = ssre_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push_valid,
	output logic                       push_ready,
	input  logic [W-1:0]               push_data,
	output logic                       pop_valid,
	input  logic                       pop_ready,
	output logic [W-1:0]               pop_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import ssre_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];
	assign count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

/* rtl/ssre_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssre_back: x store, fixed-point multiply and row accumulation
// Executes queued words in order and drives the result register.
// ----------------------------------------------------------------------------
module ssre_back #(
	parameter int HALO_DEPTH = ssre_pkg::HALO_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  ssre_pkg::op_ctrl_t            pop_ctrl,
	input  logic [$clog2(HALO_DEPTH)-1:0] pop_addr,
	ssre_result_if.source                 result
);
	import ssre_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE, B_READ, B_MUL, B_MID, B_HI, B_RES, B_ACC, B_EMIT
	} bstate_t;

	localparam logic [63:0] SMAX = {1'b0, {63{1'b1}}};
	localparam logic [63:0] SMIN = {1'b1, {63{1'b0}}};

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		r = a + b;
		if (!a[63] && !b[63] && r[63]) begin
			return SMAX;
		end else if (a[63] && b[63] && !r[63]) begin
			return SMIN;
		end
		return r;
	endfunction

	bstate_t state_q;

	logic [63:0] xmem [HALO_DEPTH];
	logic [63:0] x_rd_q;
	logic        pop;

	logic [63:0] coef_q;
	logic        last_q;
	logic [HALO_IDX_W-1:0] ohalo_q;

	logic [63:0] ma_q, mb_q;
	logic        neg_q;
	logic [1:0]  cnt_q;
	logic [63:0] pp_q [4];
	logic [31:0] a_h, b_h;
	logic [33:0] mid_q;
	logic [63:0] hi_q;
	logic [63:0] q;
	logic        rnd, ovf;
	logic [63:0] prod;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic        emit_go;

	logic        res_valid_q;
	logic [HALO_IDX_W-1:0] res_halo_q;
	logic [63:0] res_sum_q;

	assign pop_ready = (state_q == B_IDLE);
	assign pop       = pop_valid && pop_ready;
	assign emit_go   = !res_valid_q || result.ready;

	always_comb begin
		a_h  = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
		b_h  = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
		q    = {hi_q[31:0], mid_q[31:0]};
		rnd  = (pp_q[0][31:0] != '0);
		ovf  = (hi_q[63:32] != '0) || q[63];
		if (!neg_q) begin
			prod = ovf ? SMAX : q;
		end else if (ovf) begin
			prod = SMIN;
		end else begin
			// round toward minus infinity: -(q + 1) is ~q
			prod = rnd ? ~q : (64'd0 - q);
		end
	end

	// x store, one port
	always_ff @(posedge clk) begin
		if (pop) begin
			if (pop_ctrl.kind == OP_LOAD) begin
				xmem[pop_addr] <= pop_ctrl.value;
			end
			x_rd_q <= xmem[pop_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			acc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && result.ready) res_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (pop && pop_ctrl.kind == OP_MAC) begin
						if (pop_ctrl.hit) begin
							state_q <= B_READ;
						end else if (pop_ctrl.last) begin
							state_q <= B_EMIT;
						end
					end
				end
				B_READ: begin
					cnt_q   <= '0;
					state_q <= B_MUL;
				end
				B_MUL: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) state_q <= B_MID;
				end
				B_MID: state_q <= B_HI;
				B_HI:  state_q <= B_RES;
				B_RES: state_q <= B_ACC;
				B_ACC: begin
					acc_q   <= sat_add(acc_q, prod_q);
					state_q <= last_q ? B_EMIT : B_IDLE;
				end
				B_EMIT: begin
					if (emit_go) begin
						res_valid_q <= 1'b1;
						acc_q       <= '0;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop) begin
					coef_q  <= pop_ctrl.value;
					last_q  <= pop_ctrl.last;
					ohalo_q <= pop_ctrl.halo_index;
				end
			end
			B_READ: begin
				ma_q  <= coef_q[63] ? (64'd0 - coef_q) : coef_q;
				mb_q  <= x_rd_q[63] ? (64'd0 - x_rd_q) : x_rd_q;
				neg_q <= coef_q[63] ^ x_rd_q[63];
			end
			B_MUL: pp_q[cnt_q] <= 64'(a_h) * 64'(b_h);
			B_MID: mid_q <= 34'(pp_q[0][63:32]) + 34'(pp_q[1][31:0]) + 34'(pp_q[2][31:0]);
			B_HI: begin
				hi_q <= pp_q[3] + 64'(pp_q[1][63:32]) + 64'(pp_q[2][63:32])
					+ 64'(mid_q[33:32]);
			end
			B_RES: prod_q <= prod;
			B_EMIT: begin
				if (emit_go) begin
					res_halo_q <= ohalo_q;
					res_sum_q  <= acc_q;
				end
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	assign result.valid      = res_valid_q;
	assign result.halo_index = res_halo_q;
	assign result.row_sum    = res_sum_q;

endmodule
`default_nettype wire

/* rtl/striped_stencil_spmv_row_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// striped_stencil_spmv_row_engine: diagonal-format stencil row engine
// Halo x store, stripe offsets and a saturating Q31.32 row accumulator.
// ----------------------------------------------------------------------------
// usage
//   item channel: one word per x load (mode 0), stripe offset load (mode 1)
//   or matrix element (mode 2); mode 3 words are dropped
//   result channel: one word per matrix element flagged row_end, carrying the
//   row's halo address and its saturated sum
//   cfg port: write-only sizes and origin, change only while the engine idles
// operation
//   x load: queued from the front's push state, stored by the back
//   offset load: the table is written in the front, nothing is queued
//   matrix element: two divisions split the row; when the neighbor is
//   outside the grid and the row goes on, the element ends there, else one
//   halo address is found, two with both (neighbor inside and row_end),
//   each by two more divisions on the shared 50-bit divider
//   the back takes one element at a time and overlaps the front through a
//   4-word queue; the result is registered after the closing element
// reset clears control state and the accumulator; stores hold garbage until
// loaded. a stalled result register blocks the back, the queue then fills and
// the front waits in its push state, so nothing is dropped
// HALO_DEPTH and MAX_STRIPES must be powers of two
// ----------------------------------------------------------------------------
module striped_stencil_spmv_row_engine #(
	parameter int HALO_DEPTH  = ssre_pkg::HALO_DEPTH_DEF,
	parameter int MAX_STRIPES = ssre_pkg::MAX_STRIPES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ssre_item_if.sink                       item,
	ssre_result_if.source                   result,
	input  logic                            cfg_we,
	input  logic [ssre_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssre_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import ssre_pkg::*;

	localparam int AW  = $clog2(HALO_DEPTH);
	localparam int QW  = $bits(op_ctrl_t) + AW;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	// configuration registers
	cfg_t cfg_q;

	// front to queue
	logic     push_valid, push_ready;
	op_ctrl_t push_ctrl;
	logic [AW-1:0] push_addr;

	// queue to back
	logic     pop_valid, pop_ready;
	logic [QW-1:0] pop_data;
	op_ctrl_t pop_ctrl;
	logic [AW-1:0] pop_addr;
	logic [QCW-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_x_size  <= 5'd16;
			cfg_q.local_y_size  <= 5'd16;
			cfg_q.global_x_size <= 16'd16;
			cfg_q.global_y_size <= 16'd16;
			cfg_q.global_z_size <= 16'd16;
			cfg_q.origin_x      <= '0;
			cfg_q.origin_y      <= '0;
			cfg_q.origin_z      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOCAL_X:  cfg_q.local_x_size  <= cfg_wdata[4:0];
				REG_LOCAL_Y:  cfg_q.local_y_size  <= cfg_wdata[4:0];
				REG_GLOBAL_X: cfg_q.global_x_size <= cfg_wdata;
				REG_GLOBAL_Y: cfg_q.global_y_size <= cfg_wdata;
				REG_GLOBAL_Z: cfg_q.global_z_size <= cfg_wdata;
				REG_ORIGIN_X: cfg_q.origin_x      <= cfg_wdata;
				REG_ORIGIN_Y: cfg_q.origin_y      <= cfg_wdata;
				REG_ORIGIN_Z: cfg_q.origin_z      <= cfg_wdata;
				default:      cfg_q               <= cfg_q;
			endcase
		end
	end

	// front: intake, stripe table, row and neighbor address math
	ssre_front #(
		.HALO_DEPTH  (HALO_DEPTH),
		.MAX_STRIPES (MAX_STRIPES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_ctrl  (push_ctrl),
		.push_addr  (push_addr)
	);

	// decoupling queue
	ssre_queue #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_ctrl, push_addr}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.count      (q_count)
	);

	assign pop_ctrl = pop_data[QW-1:AW];
	assign pop_addr = pop_data[AW-1:0];

	// back: x store, multiply, accumulate, result register
	ssre_back #(
		.HALO_DEPTH (HALO_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_ctrl  (pop_ctrl),
		.pop_addr  (pop_addr),
		.result    (result)
	);

`ifndef ASSERT_OFF
	// queue never holds more words than it has room for
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCW'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// queue occupancy moves by at most one word per cycle
	a_queue_step: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count == $past(q_count)) || (q_count == $past(q_count) + QCW'(1)) ||
		(q_count == $past(q_count) - QCW'(1)))
		else $error("queue count jumped");

	// no result is offered straight out of reset
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !result.valid)
		else $error("result valid after reset");
`endif

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the striped stencil row engine
// Preloads the stripe table, then runs a directed burst and random rows under
// several size and origin settings. A shadow model predicts each row's halo
// address and saturated sum, checked in order on the result side.
// ----------------------------------------------------------------------------
module tb;
	import ssre_pkg::*;

	localparam int HALO_N   = HALO_DEPTH_DEF;
	localparam int STRIPE_N = MAX_STRIPES_DEF;
	localparam longint Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint Q_MIN = 64'sh8000_0000_0000_0000;

	typedef struct {
		mode_t       mode;
		logic [12:0] slot;
		logic [11:0] row;
		logic [63:0] value;
		logic        row_end;
	} word_t;

	typedef struct {
		logic [12:0] halo_index;
		logic [63:0] row_sum;
	} row_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ssre_item_if   item ();
	ssre_result_if result ();

	striped_stencil_spmv_row_engine uut (
		.clk(clk), .arst_n(arst_n), .item(item.sink), .result(result.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// shadow copy of the engine's state
	logic signed [63:0] x_shadow [HALO_N];
	logic signed [63:0] offset_shadow [STRIPE_N];
	logic signed [63:0] row_acc;
	cfg_t               sizes;

	// what the generated words will have loaded, tracked as words are made
	bit          x_loaded [HALO_N];
	longint      gen_off [STRIPE_N];
	int          words_made = 0;

	word_t       word_q [$];   // words waiting for the driver
	row_result_t sum_q [$];    // predicted row results, oldest first
	int          errors = 0;
	int          cyc = 0;
	logic        calm;         // no idling on either side
	logic        hold;         // long result-side hold-off

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	always @(posedge clk) cyc <= cyc + 1;
	assign hold = (cyc >= 5000 && cyc < 25000);
	assign calm = (cyc >= 40000 && cyc < 70000);

	function automatic logic idle_roll();
		return !calm && ($urandom_range(99) < 6);
	endfunction

	// size register reading 0 acts as 1
	function automatic longint at_least_one(longint v);
		return (v == 0) ? 1 : v;
	endfunction

	// product >> 32 toward minus infinity, saturated
	function automatic longint q_mul(longint a, longint b);
		logic signed [127:0] wa, wb, p;
		wa = a;
		wb = b;
		p = (wa * wb) >>> 32;
		if (p > Q_MAX) return Q_MAX;
		if (p < Q_MIN) return Q_MIN;
		return p[63:0];
	endfunction

	function automatic longint q_add(longint a, longint b);
		logic signed [64:0] s;
		s = 65'(signed'(a)) + 65'(signed'(b));
		if (s > Q_MAX) return Q_MAX;
		if (s < Q_MIN) return Q_MIN;
		return s[63:0];
	endfunction

	// global index to halo address, wrapped into the store
	function automatic logic [12:0] halo_addr(longint g);
		longint nx, ny, gnx, gny, hx, hy, hz, h;
		nx  = at_least_one(sizes.local_x_size);
		ny  = at_least_one(sizes.local_y_size);
		gnx = at_least_one(sizes.global_x_size);
		gny = at_least_one(sizes.global_y_size);
		hx  = g % gnx - longint'(sizes.origin_x) + 1;
		hy  = (g / gnx) % gny - longint'(sizes.origin_y) + 1;
		hz  = g / (gnx * gny) - longint'(sizes.origin_z) + 1;
		h   = (hx + hy * (nx + 2) + hz * ((nx + 2) * (ny + 2))) % HALO_N;
		if (h < 0) h += HALO_N;
		return h[12:0];
	endfunction

	// apply one accepted word to the shadow state, queue any row result
	function automatic void apply_word(word_t w);
		longint nx, ny, gnx, gny, gnz, r, gi, total, off;
		row_result_t res;
		case (w.mode)
			MODE_LOAD_X:   x_shadow[w.slot % HALO_N] = w.value;
			MODE_LOAD_OFF: offset_shadow[w.slot % STRIPE_N] = w.value;
			MODE_MAC: begin
				nx  = at_least_one(sizes.local_x_size);
				ny  = at_least_one(sizes.local_y_size);
				gnx = at_least_one(sizes.global_x_size);
				gny = at_least_one(sizes.global_y_size);
				gnz = at_least_one(sizes.global_z_size);
				r   = w.row;
				gi  = (longint'(sizes.origin_x) + r % nx)
					+ (longint'(sizes.origin_y) + (r / nx) % ny) * gnx
					+ (longint'(sizes.origin_z) + r / (nx * ny)) * (gnx * gny);
				total = gnx * gny * gnz;
				off = offset_shadow[w.slot % STRIPE_N];
				// neighbor outside the grid adds nothing
				if (off >= -gi && off < total - gi)
					row_acc = q_add(row_acc, q_mul(w.value, x_shadow[halo_addr(gi + off)]));
				if (w.row_end) begin
					res.halo_index = halo_addr(gi);
					res.row_sum    = row_acc;
					sum_q.push_back(res);
					row_acc = 0;
				end
			end
			default: ;   // unused mode is dropped
		endcase
	endfunction

	// driver: present the next word when the channel is free, unless an idle is rolled
	always @(posedge clk or negedge arst_n) begin : drive_words
		word_t w;
		if (!arst_n) begin
			item.valid <= 1'b0;
		end else begin
			if (item.valid && item.ready) begin
				w.mode    = mode_t'(item.mode);
				w.slot    = item.slot;
				w.row     = item.row;
				w.value   = item.value;
				w.row_end = item.row_end;
				apply_word(w);
			end
			if (!item.valid || item.ready) begin
				if (word_q.size() != 0 && !idle_roll()) begin
					w = word_q.pop_front();
					item.mode    <= w.mode;
					item.slot    <= w.slot;
					item.row     <= w.row;
					item.value   <= w.value;
					item.row_end <= w.row_end;
					item.valid   <= 1'b1;
				end else begin
					item.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each row result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : check_rows
		row_result_t e;
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (sum_q.size() == 0) begin
					$display("%0t: unexpected row word halo %0d sum %0d", $time,
						result.halo_index, $signed(result.row_sum));
					errors++;
				end else begin
					e = sum_q.pop_front();
					if (result.halo_index !== e.halo_index) begin
						$display("%0t: halo_index expected %0d actual %0d", $time,
							e.halo_index, result.halo_index);
						errors++;
					end
					if (result.row_sum !== e.row_sum) begin
						$display("%0t: row_sum expected %0d actual %0d", $time,
							$signed(e.row_sum), $signed(result.row_sum));
						errors++;
					end
				end
			end
			result.ready <= !(hold || idle_roll());
		end
	end

	// Q31.32 value: mostly moderate, sometimes full range or an extreme
	function automatic logic [63:0] rand_q();
		longint v;
		case ($urandom_range(9))
			0: return {$urandom, $urandom};
			1: return Q_MAX;
			2: return Q_MIN;
			default: begin
				v = longint'(signed'($urandom));
				return v <<< $urandom_range(12);
			end
		endcase
	endfunction

	// stripe offset: a stencil neighbor step under the current sizes, or noise
	function automatic logic [63:0] rand_offset();
		longint gnx, plane, step;
		gnx   = at_least_one(sizes.global_x_size);
		plane = gnx * at_least_one(sizes.global_y_size);
		case ($urandom_range(5))
			0: step = 0;
			1: step = 1;
			2: step = gnx;
			3: step = plane;
			4: step = 1 + gnx + plane;
			default: return {$urandom, $urandom};
		endcase
		return $urandom_range(1) ? step : -step;
	endfunction

	function automatic logic [11:0] rand_row();
		return $urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(300));
	endfunction

	// global index of a local row under the current sizes
	function automatic longint global_row(longint r);
		longint nx, ny, gnx, gny;
		nx  = at_least_one(sizes.local_x_size);
		ny  = at_least_one(sizes.local_y_size);
		gnx = at_least_one(sizes.global_x_size);
		gny = at_least_one(sizes.global_y_size);
		return (longint'(sizes.origin_x) + r % nx)
			+ (longint'(sizes.origin_y) + (r / nx) % ny) * gnx
			+ (longint'(sizes.origin_z) + r / (nx * ny)) * (gnx * gny);
	endfunction

	function automatic longint grid_total();
		return at_least_one(sizes.global_x_size) * at_least_one(sizes.global_y_size)
			* at_least_one(sizes.global_z_size);
	endfunction

	// queue a word; an x word goes ahead of any element whose neighbor
	// would read a halo address that nothing has loaded yet
	function automatic void push_word(mode_t m, logic [12:0] s, logic [11:0] r,
		logic [63:0] v, logic e);
		word_t w;
		longint gi, off;
		logic [12:0] h;
		if (m == MODE_MAC) begin
			gi  = global_row(r);
			off = gen_off[s % STRIPE_N];
			if (off >= -gi && off < grid_total() - gi) begin
				h = halo_addr(gi + off);
				if (!x_loaded[h]) begin
					w.mode = MODE_LOAD_X; w.slot = h; w.row = 12'($urandom);
					w.value = rand_q(); w.row_end = 1'($urandom);
					word_q.push_back(w);
					x_loaded[h] = 1'b1;
					words_made++;
				end
			end
		end
		if (m == MODE_LOAD_X) x_loaded[s % HALO_N] = 1'b1;
		if (m == MODE_LOAD_OFF) gen_off[s % STRIPE_N] = v;
		w.mode = m; w.slot = s; w.row = r; w.value = v; w.row_end = e;
		word_q.push_back(w);
		words_made++;
	endfunction

	// write every register; local sizes carry random junk above bit 4
	task automatic write_sizes(cfg_t c);
		reg_idx_t idx;
		for (int i = 0; i < 8; i++) begin
			idx = reg_idx_t'(i);
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			case (idx)
				REG_LOCAL_X:  cfg_wdata <= {11'($urandom), c.local_x_size};
				REG_LOCAL_Y:  cfg_wdata <= {11'($urandom), c.local_y_size};
				REG_GLOBAL_X: cfg_wdata <= c.global_x_size;
				REG_GLOBAL_Y: cfg_wdata <= c.global_y_size;
				REG_GLOBAL_Z: cfg_wdata <= c.global_z_size;
				REG_ORIGIN_X: cfg_wdata <= c.origin_x;
				REG_ORIGIN_Y: cfg_wdata <= c.origin_y;
				REG_ORIGIN_Z: cfg_wdata <= c.origin_z;
				default:      cfg_wdata <= '0;
			endcase
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		sizes = c;
	endtask

	// sender pause: everything sent and answered, then the engine's tail
	task automatic drain();
		while (word_q.size() != 0 || item.valid || sum_q.size() != 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	// random rows with some loads, dropped words and broken rows mixed in
	task automatic random_words(int target);
		int start, k;
		logic [11:0] r;
		start = words_made;
		while (words_made - start < target) begin
			case ($urandom_range(99)) inside
				[0:7]: begin
					push_word(MODE_LOAD_X, 13'($urandom), 12'($urandom), rand_q(),
						1'($urandom));
				end
				[8:13]: begin
					push_word(MODE_LOAD_OFF, 13'($urandom), 12'($urandom), rand_offset(),
						1'($urandom));
				end
				[14:15]: push_word(MODE_NONE, 13'($urandom), 12'($urandom),
					{$urandom, $urandom}, 1'($urandom));
				default: begin
					k = $urandom_range(1, 7);
					r = rand_row();
					for (int j = 0; j < k; j++) begin
						push_word(MODE_MAC, 13'($urandom),
							($urandom_range(19) == 0) ? rand_row() : r, rand_q(),
							(j == k - 1) && ($urandom_range(9) != 0));
					end
				end
			endcase
		end
	endtask

	initial begin
		cfg_t c;
		item.valid = 1'b0;
		item.mode = MODE_NONE;
		item.slot = '0;
		item.row = '0;
		item.value = '0;
		item.row_end = 1'b0;
		result.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LOCAL_X;
		cfg_wdata = '0;
		row_acc = 0;
		sizes = '{local_x_size: 16, local_y_size: 16, global_x_size: 16,
			global_y_size: 16, global_z_size: 16, origin_x: 0, origin_y: 0, origin_z: 0};
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// stripe table first, x words follow as elements need them
		for (int i = 0; i < STRIPE_N; i++)
			push_word(MODE_LOAD_OFF, 13'(i), 12'($urandom), rand_offset(), 1'($urandom));
		drain();

		// directed burst under reset sizes; row 0 sits at halo 343
		push_word(MODE_LOAD_X, 13'd8191, 12'd4095, Q_MAX, 1'b1);
		push_word(MODE_LOAD_X, 13'd343, 12'd0, Q_MAX, 1'b1);
		push_word(MODE_LOAD_OFF, 13'd8160, 12'd0, 64'd0, 1'b1);      // wraps to stripe 0
		push_word(MODE_LOAD_OFF, 13'd8191, 12'd4095, 64'd1, 1'b0);   // wraps to stripe 31
		push_word(MODE_LOAD_OFF, 13'd1, 12'd0, -64'sd1, 1'b0);
		// sum saturates high, then low
		push_word(MODE_MAC, 13'd0, 12'd0, Q_MAX, 1'b0);
		push_word(MODE_MAC, 13'd0, 12'd0, Q_MAX, 1'b1);
		push_word(MODE_MAC, 13'd0, 12'd0, Q_MIN, 1'b0);
		push_word(MODE_MAC, 13'd0, 12'd0, Q_MIN, 1'b1);
		// neighbor below the grid still closes the row
		push_word(MODE_MAC, 13'd1, 12'd0, 64'h1_0000_0000, 1'b1);
		// last stripe from the last local row
		push_word(MODE_MAC, 13'd8191, 12'd4095, 64'h0000_0000_8000_0000, 1'b1);
		// dropped word, row_end or not
		push_word(MODE_NONE, 13'd8191, 12'd4095, Q_MIN, 1'b1);
		// rows mixed without row_end, closed by another row
		push_word(MODE_MAC, 13'd0, 12'd5, 64'h2_0000_0000, 1'b0);
		push_word(MODE_MAC, 13'd31, 12'd6, -64'sh3_0000_0000, 1'b1);
		push_word(MODE_MAC, 13'd4096, 12'd2047, 64'd1, 1'b1);
		random_words(110);
		drain();

		// smallest sizes
		c = '{local_x_size: 1, local_y_size: 1, global_x_size: 1, global_y_size: 1,
			global_z_size: 1, origin_x: 0, origin_y: 0, origin_z: 0};
		write_sizes(c);
		random_words(110);
		drain();

		// largest grid, origin at the far corner
		c = '{local_x_size: 16, local_y_size: 16, global_x_size: 16'hFFFF,
			global_y_size: 16'hFFFF, global_z_size: 16'hFFFF, origin_x: 16'hFFFF,
			origin_y: 16'hFFFF, origin_z: 16'hFFFF};
		write_sizes(c);
		random_words(110);
		drain();

		// size registers at zero act as one
		c = '{local_x_size: 0, local_y_size: 0, global_x_size: 0, global_y_size: 0,
			global_z_size: 0, origin_x: 0, origin_y: 0, origin_z: 0};
		write_sizes(c);
		random_words(100);
		drain();

		// local sizes past the usual range, full-width register bits
		c = '{local_x_size: 31, local_y_size: 31, global_x_size: 16'($urandom),
			global_y_size: 16'($urandom), global_z_size: 16'($urandom),
			origin_x: 16'($urandom), origin_y: 16'($urandom), origin_z: 16'($urandom)};
		write_sizes(c);
		random_words(100);
		drain();

		// a plausible subdomain inside a modest grid
		for (int p = 0; p < 2; p++) begin
			c.local_x_size  = 5'($urandom_range(1, 16));
			c.local_y_size  = 5'($urandom_range(1, 16));
			c.global_x_size = 16'($urandom_range(16, 64));
			c.global_y_size = 16'($urandom_range(16, 64));
			c.global_z_size = 16'($urandom_range(4, 32));
			c.origin_x      = 16'($urandom_range(0, 40));
			c.origin_y      = 16'($urandom_range(0, 40));
			c.origin_z      = 16'($urandom_range(0, 8));
			write_sizes(c);
			random_words(90);
			drain();
		end

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// run limit
	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule

/* striped_stencil_spmv_row_engine.f */
rtl/ssre_pkg.sv
rtl/ssre_if.sv
rtl/ssre_div.sv
rtl/ssre_front.sv
rtl/ssre_queue.sv
rtl/ssre_back.sv
rtl/striped_stencil_spmv_row_engine.sv
verif/tb.sv
